// ----- hdl/sbsh_pkg.sv -----
// Shared types, round constants and SHA-256 mixing functions for the byte-stream hasher.
package sbsh_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic start;
        logic init;
    } t_cmp_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cmp_stat;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned NUM_WORDS  = 8;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    localparam t_word INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word f_big0(input t_word x);
        return ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
    endfunction

    function automatic t_word f_big1(input t_word x);
        return ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
    endfunction

    function automatic t_word f_small0(input t_word x);
        return ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
    endfunction

    function automatic t_word f_small1(input t_word x);
        return ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
    endfunction

endpackage

// ----- hdl/sbsh_in_if.sv -----
// Input channel: one message byte per beat with its flags.
interface sbsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output has_byte, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last_byte,
                  output ready);
endinterface

// ----- hdl/sbsh_out_if.sv -----
// Output channel: one digest word per beat with its position.
interface sbsh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// ----- hdl/sbsh_compress.sv -----
// Iterative SHA-256 compression unit: one round per cycle, then a fold into the chaining value.
module sbsh_compress (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbsh_pkg::t_cmp_ctrl i_ctrl,
    input  sbsh_pkg::t_word     i_w,
    output sbsh_pkg::t_cmp_stat o_stat,
    output sbsh_pkg::t_word     o_hash [0:7]
);

    sbsh_pkg::t_word r_hash [0:7];
    sbsh_pkg::t_word r_v    [0:7];
    logic [5:0]      r_t;
    logic            r_busy;
    logic            r_fold;

    sbsh_pkg::t_word n_sum1;
    sbsh_pkg::t_word n_sum2;

    always_comb begin
        n_sum1 = r_v[7] + sbsh_pkg::f_big1(r_v[4])
               + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
               + sbsh_pkg::ROUND_K[r_t] + i_w;
        n_sum2 = sbsh_pkg::f_big0(r_v[0])
               + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_t    <= '0;
            for (int j = 0; j < 8; j++) begin
                r_hash[j] <= sbsh_pkg::INIT_HASH[j];
            end
        end else begin
            if (i_ctrl.init) begin
                for (int j = 0; j < 8; j++) begin
                    r_hash[j] <= sbsh_pkg::INIT_HASH[j];
                end
            end
            if (i_ctrl.start) begin
                for (int j = 0; j < 8; j++) begin
                    r_v[j] <= r_hash[j];
                end
                r_t    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + n_sum1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= n_sum1 + n_sum2;
                r_t    <= r_t + 6'd1;
                if (r_t == 6'(sbsh_pkg::NUM_ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_fold <= 1'b1;
                end
            end else if (r_fold) begin
                for (int j = 0; j < 8; j++) begin
                    r_hash[j] <= r_hash[j] + r_v[j];
                end
                r_fold <= 1'b0;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_fold;
    assign o_hash      = r_hash;

endmodule

// ----- hdl/sha256_byte_stream_hasher_core.sv -----
// SHA-256 byte-stream hasher top level: byte buffer, schedule window, padding and digest output.
// A byte that does not fill the block and is not the last leaves the input ready for the next byte.
// A byte that completes a 64-byte block starts a compression (start, rounds, fold),
// and the input stays not ready until the one-round-per-cycle unit is done.
// A final beat adds padding, one or two compressions and eight output beats.
// Synchronous active-low reset restores the initial hash value and clears length and fill.
module sha256_byte_stream_hasher_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sbsh_in_if.sink        i_in,
    sbsh_out_if.source     o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_ZERO,
        S_LEN,
        S_COMP,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    t_state              r_ret, n_ret;
    logic [5:0]          r_fill, n_fill;
    logic [63:0]         r_bitlen, n_bitlen;
    logic                r_start, n_start;
    logic [2:0]          r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    sbsh_pkg::t_word     r_out_word, n_out_word;
    logic [2:0]          r_out_idx, n_out_idx;
    logic                r_out_last, n_out_last;

    logic [7:0]          r_buf [0:63];

    logic                n_push;
    logic [7:0]          n_byte;
    logic                n_init;
    logic                in_acc;

    sbsh_pkg::t_cmp_ctrl cmp_ctrl;
    sbsh_pkg::t_cmp_stat cmp_stat;
    sbsh_pkg::t_word     hash [0:7];
    sbsh_pkg::t_word     win  [0:15];
    sbsh_pkg::t_word     w_new;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            win[i] = {r_buf[4*i], r_buf[4*i+1], r_buf[4*i+2], r_buf[4*i+3]};
        end
        w_new = sbsh_pkg::f_small1(win[14]) + win[9] + sbsh_pkg::f_small0(win[1]) + win[0];
    end

    assign cmp_ctrl.start = r_start;
    assign cmp_ctrl.init  = n_init;

    sbsh_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cmp_ctrl),
        .i_w     (win[0]),
        .o_stat  (cmp_stat),
        .o_hash  (hash)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_bitlen    = r_bitlen;
        n_start     = 1'b0;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_push      = 1'b0;
        n_byte      = i_in.data_byte;
        n_init      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.has_byte) begin
                        n_push   = 1'b1;
                        n_bitlen = r_bitlen + 64'd8;
                        if (r_fill == 6'd63) begin
                            n_state = S_COMP;
                            n_start = 1'b1;
                            n_ret   = i_in.last_byte ? S_PAD80 : S_IDLE;
                        end else if (i_in.last_byte) begin
                            n_state = S_PAD80;
                        end
                    end else if (i_in.last_byte) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                n_push = 1'b1;
                n_byte = sbsh_pkg::PAD_BYTE;
                if (r_fill == 6'd63) begin
                    n_state = S_COMP;
                    n_start = 1'b1;
                    n_ret   = S_ZERO;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (r_fill == 6'd56) begin
                    n_state = S_LEN;
                end else begin
                    n_push = 1'b1;
                    n_byte = 8'h00;
                    if (r_fill == 6'd63) begin
                        n_state = S_COMP;
                        n_start = 1'b1;
                        n_ret   = S_ZERO;
                    end
                end
            end
            S_LEN: begin
                n_push = 1'b1;
                n_byte = r_bitlen[{~r_fill[2:0], 3'b000} +: 8];
                if (r_fill == 6'd63) begin
                    n_state = S_COMP;
                    n_start = 1'b1;
                    n_ret   = S_OUT;
                    n_idx   = '0;
                end
            end
            S_COMP: begin
                if (cmp_stat.done) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = hash[r_idx];
                    n_out_idx   = r_idx;
                    n_out_last  = (r_idx == 3'(sbsh_pkg::NUM_WORDS - 1));
                    n_idx       = r_idx + 3'd1;
                    if (r_idx == 3'(sbsh_pkg::NUM_WORDS - 1)) begin
                        n_init   = 1'b1;
                        n_bitlen = '0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_fill = n_push ? r_fill + 6'd1 : r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_fill      <= '0;
            r_bitlen    <= '0;
            r_start     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_fill      <= n_fill;
            r_bitlen    <= n_bitlen;
            r_start     <= n_start;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    // Bytes enter at the tail; during rounds the window advances by one word.
    always_ff @(posedge i_clk) begin
        if (cmp_stat.busy) begin
            for (int i = 0; i < 60; i++) begin
                r_buf[i] <= r_buf[i+4];
            end
            r_buf[60] <= w_new[31:24];
            r_buf[61] <= w_new[23:16];
            r_buf[62] <= w_new[15:8];
            r_buf[63] <= w_new[7:0];
        end else if (n_push) begin
            for (int i = 0; i < 63; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[63] <= n_byte;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_word = r_out_word;
    assign o_out.word_index  = r_out_idx;
    assign o_out.last_word   = r_out_last;

endmodule
